/* rtl/hsvrgb_pkg.sv */
`default_nettype none

package hsvrgb_pkg;

  // Field widths
  localparam int unsigned HueW  = 9;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ChanW = 8;

  // Internal widths
  localparam int unsigned FracW  = 6;   // position inside a 60 degree sector, 0..60
  localparam int unsigned WgtW   = 13;  // per-channel weight, at most 6000
  localparam int unsigned PartW  = 20;  // v * weight, at most 600000
  localparam int unsigned ScaleW = 24;  // part * 17, at most 10200000
  localparam int unsigned RecipW = 25;
  localparam int unsigned ProdW  = ScaleW + RecipW;

  // Arithmetic constants
  localparam logic [PctW-1:0]  FullPct   = 7'd100;
  localparam logic [FracW-1:0] SectorDeg = 6'd60;
  localparam logic [WgtW-1:0]  FullWgt   = 13'd6000;
  localparam logic [ChanW-1:0] AlphaOpaque = 8'hFF;

  // floor(t * 255 / 600000) == floor(t * 17 / 40000); divide by 40000 through
  // ceil(2^40 / 40000), exact for any dividend below 2^24
  localparam logic [RecipW-1:0] Recip40k   = 25'd27487791;
  localparam int unsigned       RecipShift = 40;

  // Hue sector boundaries
  localparam logic [HueW-1:0] Hue60  = 9'd60;
  localparam logic [HueW-1:0] Hue120 = 9'd120;
  localparam logic [HueW-1:0] Hue180 = 9'd180;
  localparam logic [HueW-1:0] Hue240 = 9'd240;
  localparam logic [HueW-1:0] Hue300 = 9'd300;
  localparam logic [HueW-1:0] Hue360 = 9'd360;

  typedef enum logic [2:0] {
    SecRedYel,
    SecYelGrn,
    SecGrnCyn,
    SecCynBlu,
    SecBluMag,
    SecMagRed,
    SecNone
  } sector_e;

endpackage

`default_nettype wire

/* rtl/hsvrgb_if.sv */
`default_nettype none

// HSV pixel word
interface hsvrgb_in_if;
  logic                              valid;
  logic                              ready;
  logic [hsvrgb_pkg::HueW-1:0]       hue;
  logic [hsvrgb_pkg::PctW-1:0]       saturation;
  logic [hsvrgb_pkg::PctW-1:0]       brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// RGBA pixel word
interface hsvrgb_out_if;
  logic                              valid;
  logic                              ready;
  logic [hsvrgb_pkg::ChanW-1:0]      red;
  logic [hsvrgb_pkg::ChanW-1:0]      green;
  logic [hsvrgb_pkg::ChanW-1:0]      blue;
  logic [hsvrgb_pkg::ChanW-1:0]      alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

`default_nettype wire

/* rtl/hsv_to_rgb_pixel.sv */
// HSV to RGBA pixel converter.
// Accepted words pass stage registers 1 to 6 to pix_o. Throughput: one word
// per cycle while pix_o.ready is high; each of the six register stages takes
// a new word whenever it is empty or its successor advances, so bubbles collapse.
// Reset clears the stage valid bits only; the data registers are not reset.
`default_nettype none

module hsv_to_rgb_pixel (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  hsvrgb_in_if.sink           pix_i,
  hsvrgb_out_if.source        pix_o
);

  // Stage enables and valid bits
  logic [6:1] vld_q;
  logic [6:1] en;

  always_comb begin
    en[6] = !vld_q[6] || pix_o.ready;
    en[5] = !vld_q[5] || en[6];
    en[4] = !vld_q[4] || en[5];
    en[3] = !vld_q[3] || en[4];
    en[2] = !vld_q[2] || en[3];
    en[1] = !vld_q[1] || en[2];
  end

  assign pix_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= pix_i.valid;
      if (en[2]) vld_q[2] <= vld_q[1];
      if (en[3]) vld_q[3] <= vld_q[2];
      if (en[4]) vld_q[4] <= vld_q[3];
      if (en[5]) vld_q[5] <= vld_q[4];
      if (en[6]) vld_q[6] <= vld_q[5];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: clamp percentages, find sector and position inside it
  // ---------------------------------------------------------------------
  logic [hsvrgb_pkg::PctW-1:0]  s1_sat_d, s1_sat_q, s1_val_d, s1_val_q;
  logic [hsvrgb_pkg::FracW-1:0] s1_frac_d, s1_frac_q;
  hsvrgb_pkg::sector_e          s1_sec_d, s1_sec_q;
  logic [hsvrgb_pkg::HueW-1:0]  s1_base;
  logic [hsvrgb_pkg::HueW-1:0]  s1_diff;

  always_comb begin
    s1_sat_d = (pix_i.saturation > hsvrgb_pkg::FullPct) ? hsvrgb_pkg::FullPct
                                                        : pix_i.saturation;
    s1_val_d = (pix_i.brightness > hsvrgb_pkg::FullPct) ? hsvrgb_pkg::FullPct
                                                        : pix_i.brightness;
    if (pix_i.hue < hsvrgb_pkg::Hue60) begin
      s1_sec_d = hsvrgb_pkg::SecRedYel;
      s1_base  = '0;
    end else if (pix_i.hue < hsvrgb_pkg::Hue120) begin
      s1_sec_d = hsvrgb_pkg::SecYelGrn;
      s1_base  = hsvrgb_pkg::Hue60;
    end else if (pix_i.hue < hsvrgb_pkg::Hue180) begin
      s1_sec_d = hsvrgb_pkg::SecGrnCyn;
      s1_base  = hsvrgb_pkg::Hue120;
    end else if (pix_i.hue < hsvrgb_pkg::Hue240) begin
      s1_sec_d = hsvrgb_pkg::SecCynBlu;
      s1_base  = hsvrgb_pkg::Hue180;
    end else if (pix_i.hue < hsvrgb_pkg::Hue300) begin
      s1_sec_d = hsvrgb_pkg::SecBluMag;
      s1_base  = hsvrgb_pkg::Hue240;
    end else if (pix_i.hue <= hsvrgb_pkg::Hue360) begin
      s1_sec_d = hsvrgb_pkg::SecMagRed;
      s1_base  = hsvrgb_pkg::Hue300;
    end else begin
      // out of range hue: grey, position unused
      s1_sec_d = hsvrgb_pkg::SecNone;
      s1_base  = '0;
    end
    s1_diff   = pix_i.hue - s1_base;
    s1_frac_d = s1_diff[hsvrgb_pkg::FracW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_sat_q  <= s1_sat_d;
      s1_val_q  <= s1_val_d;
      s1_frac_q <= s1_frac_d;
      s1_sec_q  <= s1_sec_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: secondary slope times saturation, offset weight
  // ---------------------------------------------------------------------
  logic [hsvrgb_pkg::FracW-1:0] s2_slope;
  logic [hsvrgb_pkg::PctW-1:0]  s2_unsat;
  logic [hsvrgb_pkg::WgtW-1:0]  s2_sx_d, s2_sx_q, s2_off_d, s2_off_q;
  logic [hsvrgb_pkg::PctW-1:0]  s2_val_q;
  hsvrgb_pkg::sector_e          s2_sec_q;

  always_comb begin
    // rising sectors count up, falling sectors count down
    if (s1_sec_q == hsvrgb_pkg::SecYelGrn || s1_sec_q == hsvrgb_pkg::SecCynBlu ||
        s1_sec_q == hsvrgb_pkg::SecMagRed) begin
      s2_slope = hsvrgb_pkg::SectorDeg - s1_frac_q;
    end else begin
      s2_slope = s1_frac_q;
    end
    s2_unsat = hsvrgb_pkg::FullPct - s1_sat_q;
    s2_sx_d  = hsvrgb_pkg::WgtW'(s1_sat_q) * hsvrgb_pkg::WgtW'(s2_slope);
    s2_off_d = hsvrgb_pkg::WgtW'(s2_unsat) * hsvrgb_pkg::WgtW'(hsvrgb_pkg::SectorDeg);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_sx_q  <= s2_sx_d;
      s2_off_q <= s2_off_d;
      s2_val_q <= s1_val_q;
      s2_sec_q <= s1_sec_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: secondary channel weight
  // ---------------------------------------------------------------------
  logic [hsvrgb_pkg::WgtW:0]    s3_sum;
  logic [hsvrgb_pkg::WgtW-1:0]  s3_wx_q, s3_wm_q;
  logic [hsvrgb_pkg::PctW-1:0]  s3_val_q;
  hsvrgb_pkg::sector_e          s3_sec_q;

  // at most 6000, so the carry is always clear
  assign s3_sum = {1'b0, s2_sx_q} + {1'b0, s2_off_q};

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_wx_q  <= s3_sum[hsvrgb_pkg::WgtW-1:0];
      s3_wm_q  <= s2_off_q;
      s3_val_q <= s2_val_q;
      s3_sec_q <= s2_sec_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: scale weights by value
  // ---------------------------------------------------------------------
  logic [hsvrgb_pkg::PartW-1:0] s4_pc_q, s4_px_q, s4_pm_q;
  hsvrgb_pkg::sector_e          s4_sec_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_pc_q  <= hsvrgb_pkg::PartW'(s3_val_q) * hsvrgb_pkg::PartW'(hsvrgb_pkg::FullWgt);
      s4_px_q  <= hsvrgb_pkg::PartW'(s3_val_q) * hsvrgb_pkg::PartW'(s3_wx_q);
      s4_pm_q  <= hsvrgb_pkg::PartW'(s3_val_q) * hsvrgb_pkg::PartW'(s3_wm_q);
      s4_sec_q <= s3_sec_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: route parts to channels, times 17
  // ---------------------------------------------------------------------
  logic [hsvrgb_pkg::PartW-1:0]  s5_r, s5_g, s5_b;
  logic [hsvrgb_pkg::ScaleW-1:0] s5_nr_q, s5_ng_q, s5_nb_q;

  always_comb begin
    unique case (s4_sec_q)
      hsvrgb_pkg::SecRedYel: begin s5_r = s4_pc_q; s5_g = s4_px_q; s5_b = s4_pm_q; end
      hsvrgb_pkg::SecYelGrn: begin s5_r = s4_px_q; s5_g = s4_pc_q; s5_b = s4_pm_q; end
      hsvrgb_pkg::SecGrnCyn: begin s5_r = s4_pm_q; s5_g = s4_pc_q; s5_b = s4_px_q; end
      hsvrgb_pkg::SecCynBlu: begin s5_r = s4_pm_q; s5_g = s4_px_q; s5_b = s4_pc_q; end
      hsvrgb_pkg::SecBluMag: begin s5_r = s4_px_q; s5_g = s4_pm_q; s5_b = s4_pc_q; end
      hsvrgb_pkg::SecMagRed: begin s5_r = s4_pc_q; s5_g = s4_pm_q; s5_b = s4_px_q; end
      default:               begin s5_r = s4_pm_q; s5_g = s4_pm_q; s5_b = s4_pm_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_nr_q <= (hsvrgb_pkg::ScaleW'(s5_r) << 4) + hsvrgb_pkg::ScaleW'(s5_r);
      s5_ng_q <= (hsvrgb_pkg::ScaleW'(s5_g) << 4) + hsvrgb_pkg::ScaleW'(s5_g);
      s5_nb_q <= (hsvrgb_pkg::ScaleW'(s5_b) << 4) + hsvrgb_pkg::ScaleW'(s5_b);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: divide by 40000 through the reciprocal, output register
  // ---------------------------------------------------------------------
  logic [hsvrgb_pkg::ProdW-1:0] s6_pr, s6_pg, s6_pb;
  logic [hsvrgb_pkg::ChanW-1:0] s6_red_q, s6_grn_q, s6_blu_q;

  assign s6_pr = hsvrgb_pkg::ProdW'(s5_nr_q) * hsvrgb_pkg::ProdW'(hsvrgb_pkg::Recip40k);
  assign s6_pg = hsvrgb_pkg::ProdW'(s5_ng_q) * hsvrgb_pkg::ProdW'(hsvrgb_pkg::Recip40k);
  assign s6_pb = hsvrgb_pkg::ProdW'(s5_nb_q) * hsvrgb_pkg::ProdW'(hsvrgb_pkg::Recip40k);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_red_q <= s6_pr[hsvrgb_pkg::RecipShift +: hsvrgb_pkg::ChanW];
      s6_grn_q <= s6_pg[hsvrgb_pkg::RecipShift +: hsvrgb_pkg::ChanW];
      s6_blu_q <= s6_pb[hsvrgb_pkg::RecipShift +: hsvrgb_pkg::ChanW];
    end
  end

  // Drive the result word
  assign pix_o.valid = vld_q[6];
  assign pix_o.red   = s6_red_q;
  assign pix_o.green = s6_grn_q;
  assign pix_o.blue  = s6_blu_q;
  assign pix_o.alpha = hsvrgb_pkg::AlphaOpaque;

endmodule

`default_nettype wire
